>>> rtl/ztma_pkg.sv
package ztma_pkg;

    // Window and zone configuration
    localparam int SAMPLES_PER_MEAN = 16;
    localparam int ZONE_COUNT       = 4;

    // Fixed field widths
    localparam int ZONE_W = 2;
    localparam int RAW_W  = 32;
    localparam int TEMP_W = 14;
    localparam int TEMP_HI = 29;
    localparam int TEMP_LO = 18;

    // Per-zone accumulator widths
    localparam int CNT_W = $clog2(SAMPLES_PER_MEAN);
    localparam int SUM_W = TEMP_W + $clog2(SAMPLES_PER_MEAN);

    // Divide by (window - 2) as multiply by reciprocal and shift
    localparam int      DIVISOR   = SAMPLES_PER_MEAN - 2;
    localparam int      DIV_SHIFT = SUM_W + $clog2(DIVISOR);
    localparam int      RECIP_W   = SUM_W + 2;
    localparam longint  RECIP_VAL = ((64'd1 << DIV_SHIFT) + longint'(DIVISOR) - 1)
                                    / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int      PROD_W    = SUM_W + RECIP_W;

    localparam logic [TEMP_W-1:0] LEAST_RESET = '1;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [SUM_W-1:0]  sum;
        logic [TEMP_W-1:0] least;
        logic [TEMP_W-1:0] greatest;
    } t_zone_ent;

    localparam t_zone_ent ENT_RESET = '{
        cnt:      '0,
        sum:      '0,
        least:    LEAST_RESET,
        greatest: '0
    };

endpackage

>>> rtl/zone_trimmed_mean_averager.sv
// Per-zone olympic-average filter for converter temperature frames. Each
// transfer on the input channel carries a zone number and a raw 32-bit frame;
// the temperature is frame bits 29:18, scaled by four (placed at bits 13:2).
// A zone's running count, sum, minimum and maximum live in a small
// synchronous state memory, one entry per zone. When a zone has seen
// SAMPLES_PER_MEAN frames, one transfer leaves on the output channel: that
// zone and (sum - min - max) / (SAMPLES_PER_MEAN - 2), after which the zone
// starts a fresh window. Frames for zones at or above ZONE_COUNT are dropped.
// Throughput is one frame per clock while no result waits under stall, any
// mix of zones, back to back: the per-zone read-modify-write follows the
// memory read, and a bypass register covers a frame that hits the zone
// written the cycle before. On the way to a valid result, the memory
// read is clocked by the input transfer, then update, trim and reciprocal
// multiply each take one register stage. The whole pipe holds while a result
// sits in the output register under stall, and o_in_stall follows that
// condition.
// No clearing pass after reset: per-zone valid bits stand in for it.
module zone_trimmed_mean_averager import ztma_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ZONE_W-1:0] i_zone,
    input  logic [RAW_W-1:0]  i_raw_word,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ZONE_W-1:0] o_out_zone,
    output logic [TEMP_W-1:0] o_mean_temp
);

    // Pipe advances unless a result waits under stall.
    logic adv;
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    logic acc_in;
    logic zone_ok;
    assign zone_ok = 32'(i_zone) < ZONE_COUNT;
    assign acc_in  = i_in_valid && adv;

    // ---------------- state memory ----------------
    t_zone_ent               r_mem [ZONE_COUNT];
    logic [ZONE_COUNT-1:0]   r_ent_vld;   // entry written since reset
    t_zone_ent               r_rd_data;
    logic                    r_rd_vld;

    // stage 1: item whose entry is being read out
    logic                    r_s1_vld;
    logic [ZONE_W-1:0]       r_s1_zone;
    logic [TEMP_W-1:0]       r_s1_temp;

    // write-back bypass: last write into the memory
    logic                    r_wb_vld;
    logic [ZONE_W-1:0]       r_wb_zone;
    t_zone_ent               r_wb_data;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_data <= r_mem[i_zone];
            r_rd_vld  <= r_ent_vld[i_zone];
            r_s1_zone <= i_zone;
            r_s1_temp <= {i_raw_word[TEMP_HI:TEMP_LO], 2'b00};
        end
    end

    // ---------------- update (stage 1) ----------------
    t_zone_ent          cur;
    t_zone_ent          upd;
    t_zone_ent          n_wr;
    logic [CNT_W:0]     cnt_inc;
    logic               done;

    always_comb begin
        if (r_wb_vld && r_wb_zone == r_s1_zone) begin
            cur = r_wb_data;
        end else if (r_rd_vld) begin
            cur = r_rd_data;
        end else begin
            cur = ENT_RESET;
        end
        cnt_inc      = {1'b0, cur.cnt} + 1'b1;
        done         = cnt_inc == (CNT_W+1)'(SAMPLES_PER_MEAN);
        upd.cnt      = cnt_inc[CNT_W-1:0];
        upd.sum      = cur.sum + SUM_W'(r_s1_temp);
        upd.least    = (r_s1_temp < cur.least) ? r_s1_temp : cur.least;
        upd.greatest = (r_s1_temp > cur.greatest) ? r_s1_temp : cur.greatest;
        n_wr         = done ? ENT_RESET : upd;
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_vld) begin
            r_mem[r_s1_zone] <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wb_zone <= r_s1_zone;
            r_wb_data <= n_wr;
        end
    end

    // ---------------- trim (stage 2) and divide (stage 3) ----------------
    logic                r_s2_vld;
    logic [ZONE_W-1:0]   r_s2_zone;
    logic [SUM_W-1:0]    r_s2_sum;
    logic [TEMP_W-1:0]   r_s2_least;
    logic [TEMP_W-1:0]   r_s2_greatest;

    logic                r_s3_vld;
    logic [ZONE_W-1:0]   r_s3_zone;
    logic [SUM_W-1:0]    r_s3_trim;

    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   quot;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_zone     <= r_s1_zone;
            r_s2_sum      <= upd.sum;
            r_s2_least    <= upd.least;
            r_s2_greatest <= upd.greatest;
            r_s3_zone     <= r_s2_zone;
            r_s3_trim     <= r_s2_sum - SUM_W'(r_s2_least) - SUM_W'(r_s2_greatest);
        end
    end

    // floor(trim / DIVISOR) exact over the whole sum range
    assign prod = PROD_W'(r_s3_trim) * PROD_W'(RECIP);
    assign quot = prod >> DIV_SHIFT;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out_zone  <= r_s3_zone;
            o_mean_temp <= quot[TEMP_W-1:0];
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld   <= '0;
            r_s1_vld    <= 1'b0;
            r_wb_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            if (r_s1_vld) begin
                r_ent_vld[r_s1_zone] <= 1'b1;
            end
            r_s1_vld    <= acc_in && zone_ok;
            r_wb_vld    <= r_s1_vld;
            r_s2_vld    <= r_s1_vld && done;
            r_s3_vld    <= r_s2_vld;
            o_out_valid <= r_s3_vld;
        end
    end

endmodule

>>> bench/tb_zone_trimmed_mean_averager.sv
module tb_zone_trimmed_mean_averager;
    timeunit 1ns;
    timeprecision 1ps;

    import ztma_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    // no random idling on either side inside this window of cycles
    localparam int CALM_FROM   = 700;
    localparam int CALM_TO     = 1300;
    localparam int RANDOM_ITEMS = 1230;

    typedef struct {
        logic [ZONE_W-1:0] zone;
        logic [RAW_W-1:0]  raw;
        bit                drain;   // hold off until every mean has arrived
    } t_frame;

    typedef struct {
        logic [ZONE_W-1:0] zone;
        logic [TEMP_W-1:0] mean;
    } t_zone_mean;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [ZONE_W-1:0] i_zone      = '0;
    logic [RAW_W-1:0]  i_raw_word  = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [ZONE_W-1:0] o_out_zone;
    logic [TEMP_W-1:0] o_mean_temp;

    zone_trimmed_mean_averager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_zone      (i_zone),
        .i_raw_word  (i_raw_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_zone  (o_out_zone),
        .o_mean_temp (o_mean_temp)
    );

    always #2 i_clk = ~i_clk;

    t_frame      frame_q[$];        // frames not yet presented
    t_zone_mean  pending_means[$];  // means predicted, not yet seen
    int          mismatch_cnt = 0;
    int          cyc = 0;
    bit          in_taken = 1'b0;   // current frame went through last edge

    // Predictor copy of each zone's window
    int unsigned       win_cnt[ZONE_COUNT];
    int unsigned       win_sum[ZONE_COUNT];
    logic [TEMP_W-1:0] win_least[ZONE_COUNT];
    logic [TEMP_W-1:0] win_greatest[ZONE_COUNT];

    wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    function automatic void restart_window(int z);
        win_cnt[z]      = 0;
        win_sum[z]      = 0;
        win_least[z]    = '1;
        win_greatest[z] = '0;
    endfunction

    // Fold one accepted frame into its zone; queue a mean when the window fills.
    function automatic void fold_sample(logic [ZONE_W-1:0] z, logic [RAW_W-1:0] raw);
        logic [TEMP_W-1:0] t;
        int unsigned       trimmed;
        t_zone_mean        m;
        // zones past the configured count are dropped without a trace
        if (int'(z) >= ZONE_COUNT) return;
        // temperature field scaled by four: frame bits 29:18 land on 13:2
        t = {raw[TEMP_HI:TEMP_LO], 2'b00};
        win_sum[z] += t;
        if (t < win_least[z]) win_least[z] = t;
        if (t > win_greatest[z]) win_greatest[z] = t;
        win_cnt[z] += 1;
        if (win_cnt[z] < SAMPLES_PER_MEAN) return;
        trimmed = win_sum[z] - win_least[z] - win_greatest[z];
        m.zone = z;
        m.mean = TEMP_W'(trimmed / (SAMPLES_PER_MEAN - 2));
        pending_means.push_back(m);
        restart_window(z);
    endfunction

    task automatic flag_mismatch(string msg);
        $display("mismatch @%0d: %s", cyc, msg);
        mismatch_cnt++;
    endtask

    function automatic void queue_frame(logic [ZONE_W-1:0] z, logic [RAW_W-1:0] raw,
                                        bit drain);
        t_frame f;
        f.zone  = z;
        f.raw   = raw;
        f.drain = drain;
        frame_q.push_back(f);
    endfunction

    // Input side: cycle count, timeout, and prediction on each input transfer.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            in_taken <= i_rst_n && i_in_valid && !o_in_stall;
            if (i_rst_n && i_in_valid && !o_in_stall)
                fold_sample(i_zone, i_raw_word);
        end
    end

    // Output side: every transfer must match the oldest pending mean.
    always @(posedge i_clk) begin : check_means
        t_zone_mean want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_means.size() == 0) begin
                flag_mismatch($sformatf("unexpected result zone %0d mean %0d",
                                        o_out_zone, o_mean_temp));
            end else begin
                want = pending_means.pop_front();
                if (o_out_zone !== want.zone)
                    flag_mismatch($sformatf("zone got %0d want %0d", o_out_zone, want.zone));
                if (o_mean_temp !== want.mean)
                    flag_mismatch($sformatf("mean zone %0d got %0d want %0d",
                                            want.zone, o_mean_temp, want.mean));
            end
        end
    end

    // Frame driver. A presented frame holds until its transfer; then the next
    // one goes out, or the channel idles at random, or waits for a drain.
    always @(negedge i_clk) begin : drive_frames
        t_frame nxt;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (frame_q.size() == 0 ||
                (frame_q[0].drain && pending_means.size() != 0) ||
                (!calm && $urandom_range(99) < 24)) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = frame_q.pop_front();
                i_in_valid <= 1'b1;
                i_zone     <= nxt.zone;
                i_raw_word <= nxt.raw;
            end
        end
    end

    // Result receiver stalls at random outside the calm window.
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_out_stall <= !calm && ($urandom_range(99) < 24);
    end

    initial begin : stimulus
        logic [RAW_W-1:0]  edge_raw[16];
        int                mode;
        int                burst;
        bit                one_zone;
        logic [ZONE_W-1:0] bz;
        logic [ZONE_W-1:0] z;
        logic [RAW_W-1:0]  raw;
        logic [RAW_W-1:0]  const_raw;
        int                n;

        for (int i = 0; i < ZONE_COUNT; i++) restart_window(i);

        // Directed: one window on zone 3 queued back to back, mixing field extremes
        // with frames whose only set bits lie outside the field.
        edge_raw = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h3FFC_0000, 32'hC003_FFFF,
                     32'h0004_0000, 32'h2000_0000, 32'h1555_5555, 32'h2AAA_AAAA,
                     32'h3FFC_0000, 32'h0000_0000, 32'h8000_0000, 32'h4000_0000,
                     32'h0003_FFFF, 32'h3FFF_FFFF, 32'hFFFC_0000, 32'h1FFC_0000};
        queue_frame(2'd0, 32'hFFFF_FFFF, 1'b0);
        queue_frame(2'd1, 32'h0000_0000, 1'b0);
        foreach (edge_raw[i]) queue_frame(2'd3, edge_raw[i], 1'b0);
        queue_frame(2'd2, 32'h8000_0000, 1'b0);
        queue_frame(2'd0, 32'hFFFF_FFFF, 1'b0);

        // Random bursts: full random frames, field extremes, a crowded top of
        // range, or one frame repeated; zones either mixed or all one zone.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            mode      = $urandom_range(3);
            burst     = $urandom_range(40, 8);
            one_zone  = 1'($urandom_range(1));
            bz        = ZONE_W'($urandom_range(3));
            const_raw = $urandom;
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
                z = one_zone ? bz : ZONE_W'($urandom_range(3));
                case (mode)
                    0: begin
                        raw = $urandom;
                    end
                    1: begin
                        raw = $urandom_range(1) ? '1 : '0;
                        if ($urandom_range(3) == 0) raw = raw ^ 32'hC003_FFFF;
                    end
                    2: begin
                        raw = $urandom;
                        raw[29:26] = 4'hF;
                    end
                    default: begin
                        raw = const_raw;
                    end
                endcase
                // two points where the sender waits for the output to drain
                queue_frame(z, raw, (n == 600) || (n == 1000));
                n++;
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (frame_q.size() != 0 || i_in_valid || pending_means.size() != 0)
            @(posedge i_clk);
        // pipeline is four deep; leave room for anything stray
        repeat (16) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_means.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
